// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hpws_pkg.sv =====
// Types and constants of the HSV pixel to LED symbol encoder.
package hpws_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int TICK_W         = 15;
    localparam int CFG_IDX_W      = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_HALF = 3'd4;

    // Reset values of the tick registers.
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 15'd3;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 15'd9;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 15'd9;
    localparam logic [TICK_W-1:0] RST_ONE_LOW    = 15'd3;
    localparam logic [TICK_W-1:0] RST_LATCH_HALF = 15'd250;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch_half;
    } t_tick_cfg;

    // Finished pixel, green/blue/red with green in the top byte.
    typedef struct packed {
        logic                      vld;
        logic [BITS_PER_PIXEL-1:0] grb;
    } t_rgb_item;

endpackage

// ===== hw/rtl/hpws_hsv_pipe.sv =====
// Six-stage HSV to RGB conversion pipeline.
`include "assert_macros.svh"

module hpws_hsv_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [8:0]         i_hue,
    input  logic [6:0]         i_saturation,
    input  logic [6:0]         i_value_level,
    input  logic               i_off,
    output hpws_pkg::t_rgb_item o_item,
    input  logic               i_ready
);
    import hpws_pkg::*;

    // floor(x/100) = (x*5243) >> 19 for x <= 25500
    localparam logic [13:0] DIV100_MUL = 14'd5243;
    // floor(q/60) = (q*17477) >> 20 for q <= 15045
    localparam logic [14:0] DIV60_MUL  = 15'd17477;

    logic en1, en2, en3, en4, en5, en6;

    // stage 1
    logic       r_v1, r_off1;
    logic [6:0] r_s1;
    logic [7:0] r_hi1;
    logic [2:0] r_sec1;
    logic [5:0] r_rem1;
    // stage 2
    logic        r_v2, r_off2;
    logic [7:0]  r_hi2;
    logic [2:0]  r_sec2;
    logic [5:0]  r_rem2;
    logic [14:0] r_p2;
    // stage 3
    logic       r_v3, r_off3;
    logic [7:0] r_hi3, r_lo3, r_d3;
    logic [2:0] r_sec3;
    logic [5:0] r_rem3;
    // stage 4
    logic        r_v4, r_off4;
    logic [7:0]  r_hi4, r_lo4, r_d4;
    logic [2:0]  r_sec4;
    logic [13:0] r_q4;
    // stage 5
    logic       r_v5, r_off5;
    logic [7:0] r_hi5, r_lo5, r_d5, r_adj5;
    logic [2:0] r_sec5;
    // stage 6
    logic                      r_v6;
    logic [BITS_PER_PIXEL-1:0] r_grb6;

    logic [8:0]  h_mod;
    logic [6:0]  s_c, v_c;
    logic [14:0] v255;
    logic [27:0] hi_prod;
    logic [2:0]  n_sec;
    logic [8:0]  sec_base;
    logic [8:0]  rem_full;
    logic [27:0] lo_prod;
    logic [7:0]  lo3;
    logic [28:0] adj_prod;
    logic [7:0]  ch_r, ch_g, ch_b, up, dn;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        h_mod   = (i_hue >= 9'd360) ? (i_hue - 9'd360) : i_hue;
        s_c     = (i_saturation > 7'd100) ? 7'd100 : i_saturation;
        v_c     = (i_value_level > 7'd100) ? 7'd100 : i_value_level;
        v255    = {v_c, 8'b0} - 15'(v_c);
        hi_prod = 28'(v255) * 28'(DIV100_MUL);
        n_sec   = 3'(h_mod >= 9'd60) + 3'(h_mod >= 9'd120) + 3'(h_mod >= 9'd180)
                + 3'(h_mod >= 9'd240) + 3'(h_mod >= 9'd300);
        case (n_sec)
            3'd0:    sec_base = 9'd0;
            3'd1:    sec_base = 9'd60;
            3'd2:    sec_base = 9'd120;
            3'd3:    sec_base = 9'd180;
            3'd4:    sec_base = 9'd240;
            default: sec_base = 9'd300;
        endcase
        rem_full = h_mod - sec_base;
        lo_prod  = 28'(r_p2) * 28'(DIV100_MUL);
        lo3      = lo_prod[26:19];
        adj_prod = 29'(r_q4) * 29'(DIV60_MUL);
        up       = r_lo5 + r_adj5;
        dn       = r_hi5 - r_adj5;
        case (r_sec5)
            3'd0: begin ch_r = r_hi5; ch_g = up;    ch_b = r_lo5; end
            3'd1: begin ch_r = dn;    ch_g = r_hi5; ch_b = r_lo5; end
            3'd2: begin ch_r = r_lo5; ch_g = r_hi5; ch_b = up;    end
            3'd3: begin ch_r = r_lo5; ch_g = dn;    ch_b = r_hi5; end
            3'd4: begin ch_r = up;    ch_g = r_lo5; ch_b = r_hi5; end
            default: begin ch_r = r_hi5; ch_g = r_lo5; ch_b = dn; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_off1 <= i_off;
            r_s1   <= s_c;
            r_hi1  <= hi_prod[26:19];
            r_sec1 <= n_sec;
            r_rem1 <= rem_full[5:0];
        end
        if (en2) begin
            r_off2 <= r_off1;
            r_hi2  <= r_hi1;
            r_sec2 <= r_sec1;
            r_rem2 <= r_rem1;
            r_p2   <= 15'(r_hi1) * (15'd100 - 15'(r_s1));
        end
        if (en3) begin
            r_off3 <= r_off2;
            r_hi3  <= r_hi2;
            r_lo3  <= lo3;
            r_d3   <= r_hi2 - lo3;
            r_sec3 <= r_sec2;
            r_rem3 <= r_rem2;
        end
        if (en4) begin
            r_off4 <= r_off3;
            r_hi4  <= r_hi3;
            r_lo4  <= r_lo3;
            r_d4   <= r_d3;
            r_sec4 <= r_sec3;
            r_q4   <= 14'(r_d3) * 14'(r_rem3);
        end
        if (en5) begin
            r_off5 <= r_off4;
            r_hi5  <= r_hi4;
            r_lo5  <= r_lo4;
            r_d5   <= r_d4;
            r_sec5 <= r_sec4;
            r_adj5 <= adj_prod[27:20];
        end
        if (en6) begin
            // drop to black on an off request
            r_grb6 <= r_off5 ? '0 : {ch_g, ch_b, ch_r};
        end
    end

    assign o_item.vld = r_v6;
    assign o_item.grb = r_grb6;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, r_v6 && !i_ready |=> r_v6 && $stable(r_grb6), "pipe lost a stalled pixel")
    `ASSERT_CLK(a_head_hold, i_clk, i_rst_n, r_v1 && !en2 |=> r_v1, "pipe dropped an item at stage one")
    `ASSERT_CLK(a_adj_range, i_clk, i_rst_n, r_v5 |-> r_adj5 <= r_d5, "hue adjustment exceeds max minus min")

endmodule

// ===== hw/rtl/hpws_ser.sv =====
// Serializer: one finished pixel into 24 bit symbols and a latch symbol.
`include "assert_macros.svh"

module hpws_ser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hpws_pkg::t_rgb_item        i_item,
    output logic                       o_ready,
    input  hpws_pkg::t_tick_cfg        i_cfg,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_level_first,
    output logic [hpws_pkg::TICK_W-1:0] o_ticks_first,
    output logic                       o_level_second,
    output logic [hpws_pkg::TICK_W-1:0] o_ticks_second,
    output logic                       o_data_bit,
    output logic                       o_last
);
    import hpws_pkg::*;

    localparam logic [4:0] LATCH_IDX = 5'(BITS_PER_PIXEL);

    logic                      r_busy;
    logic [4:0]                r_cnt;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic                      r_oval, r_olevel1, r_obit, r_olast;
    logic [TICK_W-1:0]         r_oticks1, r_oticks2;

    logic out_free, last_sym, take, bit_now;

    assign out_free = !r_oval || !i_stall;
    assign last_sym = (r_cnt == LATCH_IDX);
    assign o_ready  = !r_busy || (out_free && last_sym);
    assign take     = i_item.vld && o_ready;
    assign bit_now  = r_word[BITS_PER_PIXEL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_oval <= 1'b0;
        end else begin
            if (out_free) begin
                r_oval <= r_busy;
                if (r_busy) begin
                    r_cnt <= r_cnt + 5'd1;
                    if (last_sym) r_busy <= 1'b0;
                end
            end
            // load a new pixel; overrides the count step above
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_busy) begin
            r_word <= r_word << 1;
            if (last_sym) begin
                r_olevel1 <= 1'b0;
                r_oticks1 <= i_cfg.latch_half;
                r_oticks2 <= i_cfg.latch_half;
                r_obit    <= 1'b0;
                r_olast   <= 1'b1;
            end else begin
                r_olevel1 <= 1'b1;
                r_oticks1 <= bit_now ? i_cfg.one_high : i_cfg.zero_high;
                r_oticks2 <= bit_now ? i_cfg.one_low : i_cfg.zero_low;
                r_obit    <= bit_now;
                r_olast   <= 1'b0;
            end
        end
        if (take) r_word <= i_item.grb;
    end

    assign o_valid        = r_oval;
    assign o_level_first  = r_olevel1;
    assign o_ticks_first  = r_oticks1;
    assign o_level_second = 1'b0;
    assign o_ticks_second = r_oticks2;
    assign o_data_bit     = r_obit;
    assign o_last         = r_olast;

    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_busy |-> r_cnt <= LATCH_IDX, "symbol count past the latch")
    `ASSERT_CLK(a_start_zero, i_clk, i_rst_n, $rose(r_busy) |-> r_cnt == 5'd0, "pixel started mid count")
    `ASSERT_CLK(a_latch_low, i_clk, i_rst_n, r_oval && r_olast |-> !r_olevel1 && !r_obit, "latch symbol not all low")

endmodule

// ===== hw/rtl/hsv_pixel_to_ws2812_symbols_top.sv =====
// Top level: HSV pixel requests in, LED pulse symbols out.
//
//  channel   direction  handshake            payload
//  pixel     in         i_valid / o_stall    i_hue, i_saturation, i_value_level, i_off
//  symbol    out        o_valid / i_stall    o_level_first .. o_last
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each pixel gives 25 symbols, one per cycle while i_stall is low; the serializer takes
// the next pixel in the cycle in which it sends the latch symbol of the last one.
// A pixel enters the six-stage color pipeline in any cycle in which o_stall is low; from
// the last stage it passes the serializer's word register and then the symbol register.
// Synchronous active-low reset empties the pipeline and restores the tick registers.
// A stall holds the symbol register; pixels queue in the pipeline stages behind it.
module hsv_pixel_to_ws2812_symbols_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [8:0]                      i_hue,
    input  logic [6:0]                      i_saturation,
    input  logic [6:0]                      i_value_level,
    input  logic                            i_off,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_level_first,
    output logic [hpws_pkg::TICK_W-1:0]     o_ticks_first,
    output logic                            o_level_second,
    output logic [hpws_pkg::TICK_W-1:0]     o_ticks_second,
    output logic                            o_data_bit,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [hpws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpws_pkg::TICK_W-1:0]     i_cfg_data
);
    import hpws_pkg::*;

    t_tick_cfg r_cfg;
    t_rgb_item pix_item;
    logic      pipe_ready, ser_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high  <= RST_ZERO_HIGH;
            r_cfg.zero_low   <= RST_ZERO_LOW;
            r_cfg.one_high   <= RST_ONE_HIGH;
            r_cfg.one_low    <= RST_ONE_LOW;
            r_cfg.latch_half <= RST_LATCH_HALF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZERO_HIGH:  r_cfg.zero_high  <= i_cfg_data;
                CFG_ZERO_LOW:   r_cfg.zero_low   <= i_cfg_data;
                CFG_ONE_HIGH:   r_cfg.one_high   <= i_cfg_data;
                CFG_ONE_LOW:    r_cfg.one_low    <= i_cfg_data;
                CFG_LATCH_HALF: r_cfg.latch_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hpws_hsv_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (pipe_ready),
        .i_hue         (i_hue),
        .i_saturation  (i_saturation),
        .i_value_level (i_value_level),
        .i_off         (i_off),
        .o_item        (pix_item),
        .i_ready       (ser_ready)
    );

    hpws_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (pix_item),
        .o_ready        (ser_ready),
        .i_cfg          (r_cfg),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_level_first  (o_level_first),
        .o_ticks_first  (o_ticks_first),
        .o_level_second (o_level_second),
        .o_ticks_second (o_ticks_second),
        .o_data_bit     (o_data_bit),
        .o_last         (o_last)
    );

    assign o_stall = !pipe_ready;

endmodule
